[src/swm_pkg.sv]
// shared constants for the sliding window median filter
// no dependencies; compiled before the interfaces and the top level
`default_nettype none

package swm_pkg;

  // width and reset value of the window size register
  localparam int CFG_W = 7;
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1);

endpackage : swm_pkg

`default_nettype wire

[src/swm_stream_if.sv]
// valid/ready stream interfaces for the sliding window median filter
// sample channel in, median channel out; no dependencies
`default_nettype none

interface swm_sample_if #(
  parameter int DATA_W = 32
);
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] sample;
  logic                     start_new;

  modport source (output valid, output sample, output start_new, input ready);
  modport sink   (input valid, input sample, input start_new, output ready);
endinterface : swm_sample_if

interface swm_median_if #(
  parameter int DATA_W = 33
);
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] median_doubled;

  modport source (output valid, output median_doubled, input ready);
  modport sink   (input valid, input median_doubled, output ready);
endinterface : swm_median_if

`default_nettype wire

[src/sliding_window_median.sv]
// sliding window median filter: a sample sets the pending result, then the output
// register; one sample per cycle unless the input is held; the sorted window is updated
// by one pass of parallel compares and a per-slot four-way select, the median is read
// from the registered window; a result stall holds the input only when a pending result
// is already waiting; reset (synchronous, active high) empties the window and sets the
// window size to 1; sorted entries hold no reset value, and only filled ones are used
`default_nettype none

module sliding_window_median #(
  parameter int WINDOW_MAX  = 64,
  parameter int SAMPLE_BITS = 32
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_we,
  input  wire [swm_pkg::CFG_W-1:0]  cfg_data,
  swm_sample_if.sink                samples,
  swm_median_if.source              medians
);
  import swm_pkg::*;

  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int OUT_W = SAMPLE_BITS + 1;

  // window state
  logic [CFG_W-1:0]              window_size;
  logic [CNT_W-1:0]              fill_count;
  logic [IDX_W-1:0]              oldest_pointer;
  logic signed [SAMPLE_BITS-1:0] sorted_val [WINDOW_MAX];
  logic [IDX_W-1:0]              sorted_tag [WINDOW_MAX];

  // pending result and output register
  logic                          pend_valid;
  logic [IDX_W-1:0]              pend_lo;
  logic [IDX_W-1:0]              pend_hi;
  logic                          out_valid;
  logic signed [OUT_W-1:0]       out_data;

  // combinational update
  logic [CNT_W-1:0]              act_size;
  logic [CNT_W-1:0]              fill_cur;
  logic [IDX_W-1:0]              oldest_cur;
  logic                          full;
  logic [IDX_W-1:0]              slot_p;
  logic [CNT_W-1:0]              n_eff;
  logic [IDX_W-1:0]              new_tag;
  logic signed [SAMPLE_BITS-1:0] old_val;
  logic [WINDOW_MAX-1:0]         gt;
  logic [WINDOW_MAX-1:0]         shift_up;
  logic [WINDOW_MAX-1:0]         gt_r;
  logic signed [SAMPLE_BITS-1:0] r_val [WINDOW_MAX];
  logic [IDX_W-1:0]              r_tag [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] val_next [WINDOW_MAX];
  logic [IDX_W-1:0]              tag_next [WINDOW_MAX];
  logic [CNT_W-1:0]              fill_next;
  logic [IDX_W-1:0]              oldest_next;
  logic                          emit;
  logic [CNT_W-1:0]              lo_full;
  logic [CNT_W-1:0]              hi_full;
  logic [CNT_W-1:0]              p_inc;

  logic accept;
  logic out_stall;

  assign out_stall      = out_valid && !medians.ready;
  assign samples.ready  = !(pend_valid && out_stall);
  assign accept         = samples.valid && samples.ready;
  assign medians.valid  = out_valid;
  assign medians.median_doubled = out_data;

  // effective window length, zero counts as one and large values saturate
  always_comb begin
    if (window_size == '0) begin
      act_size = CNT_W'(1);
    end else if (int'(window_size) > WINDOW_MAX) begin
      act_size = CNT_W'(WINDOW_MAX);
    end else begin
      act_size = CNT_W'(window_size);
    end
  end

  // evict the oldest entry and insert the new sample in one pass
  always_comb begin
    int j;
    int m;
    if (samples.start_new || (fill_count > act_size)) begin
      fill_cur   = '0;
      oldest_cur = '0;
    end else begin
      fill_cur   = fill_count;
      oldest_cur = oldest_pointer;
    end
    full   = (fill_cur == act_size);
    slot_p = (CNT_W'(oldest_cur) >= act_size) ? '0 : oldest_cur;
    n_eff  = full ? (act_size - CNT_W'(1)) : fill_cur;
    new_tag = full ? slot_p : fill_cur[IDX_W-1:0];

    // value of the oldest entry, found by its ring slot tag
    old_val = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if ((CNT_W'(i) < act_size) && (sorted_tag[i] == slot_p)) begin
        old_val = old_val | sorted_val[i];
      end
    end

    // equal values sit in arrival order, so the oldest is the first copy
    for (int i = 0; i < WINDOW_MAX; i++) begin
      gt[i]       = sorted_val[i] > samples.sample;
      shift_up[i] = full && (sorted_val[i] >= old_val);
    end

    // window with the oldest entry removed
    for (int i = 0; i < WINDOW_MAX; i++) begin
      j = (i < WINDOW_MAX - 1) ? i + 1 : i;
      r_val[i] = shift_up[i] ? sorted_val[j] : sorted_val[i];
      r_tag[i] = shift_up[i] ? sorted_tag[j] : sorted_tag[i];
      gt_r[i]  = (CNT_W'(i) >= n_eff) || (shift_up[i] ? gt[j] : gt[i]);
    end

    // insert after all entries not greater than the sample
    for (int i = 0; i < WINDOW_MAX; i++) begin
      m = (i > 0) ? i - 1 : 0;
      if (!gt_r[i]) begin
        val_next[i] = r_val[i];
        tag_next[i] = r_tag[i];
      end else if ((i == 0) || !gt_r[m]) begin
        val_next[i] = samples.sample;
        tag_next[i] = new_tag;
      end else begin
        val_next[i] = r_val[m];
        tag_next[i] = r_tag[m];
      end
    end

    // fill count and oldest slot
    p_inc = CNT_W'(slot_p) + CNT_W'(1);
    if (full) begin
      fill_next   = fill_cur;
      oldest_next = (p_inc >= act_size) ? '0 : p_inc[IDX_W-1:0];
    end else begin
      fill_next   = fill_cur + CNT_W'(1);
      oldest_next = oldest_cur;
    end
    emit = (fill_next == act_size);

    // middle entries: equal for an odd window, adjacent for an even one
    lo_full = (act_size - CNT_W'(1)) >> 1;
    hi_full = act_size >> 1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size    <= CFG_RESET;
      fill_count     <= '0;
      oldest_pointer <= '0;
      pend_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_size    <= cfg_data;
        fill_count     <= '0;
        oldest_pointer <= '0;
      end else if (accept) begin
        fill_count     <= fill_next;
        oldest_pointer <= oldest_next;
      end
      if (samples.ready) begin
        pend_valid <= accept && emit;
      end
      if (!out_stall) begin
        out_valid <= pend_valid;
      end
    end
  end

  // sorted window and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
        sorted_val[i] <= val_next[i];
        sorted_tag[i] <= tag_next[i];
      end
      pend_lo <= lo_full[IDX_W-1:0];
      pend_hi <= hi_full[IDX_W-1:0];
    end
    if (!out_stall && pend_valid) begin
      out_data <= {sorted_val[pend_lo][SAMPLE_BITS-1], sorted_val[pend_lo]}
                + {sorted_val[pend_hi][SAMPLE_BITS-1], sorted_val[pend_hi]};
    end
  end

`ifndef SYNTH
  // a window size write empties the window
  a_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> (fill_count == '0) && (oldest_pointer == '0))
    else $error("window not emptied after size write");

  // the fill count never runs past the window length
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (fill_count <= act_size) || $past(cfg_we))
    else $error("fill count beyond window size");

  // the oldest slot moves only once the window is full
  a_oldest_full: assert property (@(posedge clk) disable iff (rst)
    (oldest_pointer != '0) |-> (fill_count == act_size))
    else $error("oldest slot moved while filling");

  // a new result comes only from a pending one
  a_out_from_pend: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pend_valid))
    else $error("result without pending entry");
`endif

endmodule : sliding_window_median

`default_nettype wire
